### rtl/core/b2y_pkg.sv
`timescale 1ns / 1ps

package b2y_pkg;

  // fixed sizes
  localparam int B2Y_MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT     = 2048;
  localparam int ROW_W          = 11;
  localparam int SIZE_W         = 12;
  localparam int PIX_W          = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // register map, indexed by paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } b2y_pix_t;

  // one classified pixel with its neighbours for the back end
  typedef struct packed {
    b2y_pix_t px;
    b2y_pix_t held;
    b2y_pix_t above_l;
    b2y_pix_t above_r;
    logic     chroma;
    logic     last;
  } b2y_entry_t;

  typedef struct packed {
    logic       valid;
    b2y_entry_t entry;
  } b2y_push_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } b2y_qstat_t;

endpackage

### rtl/core/b2y_pixel_if.sv
`timescale 1ns / 1ps

interface b2y_pixel_if
  import b2y_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink (input valid, input blue, input green, input red, output ready);
endinterface

### rtl/core/b2y_result_if.sv
`timescale 1ns / 1ps

interface b2y_result_if
  import b2y_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic             chroma_valid;
  logic [PIX_W-1:0] chroma_blue_diff;
  logic [PIX_W-1:0] chroma_red_diff;
  logic             frame_last;

  modport source (
    output valid, output luma, output chroma_valid, output chroma_blue_diff,
    output chroma_red_diff, output frame_last, input ready
  );
  modport sink (
    input valid, input luma, input chroma_valid, input chroma_blue_diff,
    input chroma_red_diff, input frame_last, output ready
  );
endinterface

### rtl/core/b2y_ram.sv
`timescale 1ns / 1ps

module b2y_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/b2y_queue.sv
`timescale 1ns / 1ps

module b2y_queue
  import b2y_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b2y_push_t  push_i,
  input  logic       pop_i,
  output b2y_entry_t head_o,
  output b2y_qstat_t stat_o
);

  b2y_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  // the front only pushes when it holds a credit, so push never overflows
  always_comb begin
    do_pop   = pop_i && (count_q != '0);
    wr_ptr_d = push_i.valid ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i.valid) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

### rtl/core/b2y_front.sv
`timescale 1ns / 1ps

module b2y_front
  import b2y_pkg::*;
#(
  parameter int MAX_WIDTH = B2Y_MAX_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] frame_width_i,
  input  logic [SIZE_W-1:0] frame_height_i,
  b2y_pixel_if.sink         pix,
  input  b2y_qstat_t        qstat_i,
  output b2y_push_t         push_o
);

  localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW      = (CW >= SIZE_W) ? CW + 1 : SIZE_W + 1;
  localparam int W_EVEN  = (MAX_WIDTH / 2) * 2;
  localparam int W_LIMIT = (W_EVEN < 2) ? 2 : W_EVEN;
  localparam int PAIRS   = (MAX_WIDTH + 1) / 2;
  localparam int AW      = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  logic [CW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  b2y_pix_t          held_q, held_d;
  logic              s1_valid_q;
  b2y_pix_t          s1_px_q, s1_held_q;
  logic              s1_chroma_q, s1_last_q;

  logic              accept;
  b2y_pix_t          px;
  logic [WW-1:0]     w_even, used_w, col_inc;
  logic [SIZE_W-1:0] h_even, used_h, row_inc;
  logic              row_end, frame_end;
  logic              odd_row, odd_col, chroma;
  logic              we_even, we_odd, rd_pair;
  logic [AW-1:0]     pair_addr;
  logic [23:0]       rd_even, rd_odd;

  // one slot for the pixel now in flight, one for the new one
  assign pix.ready = (qstat_i.count + QCNT_W'(s1_valid_q)) < QCNT_W'(QUEUE_DEPTH);
  assign accept    = pix.valid && pix.ready;

  // used frame size and position bookkeeping
  always_comb begin
    px.red    = pix.red;
    px.green  = pix.green;
    px.blue   = pix.blue;

    w_even    = WW'({frame_width_i[SIZE_W-1:1], 1'b0});
    if (w_even < WW'(2)) begin
      used_w = WW'(2);
    end else if (w_even > WW'(W_LIMIT)) begin
      used_w = WW'(W_LIMIT);
    end else begin
      used_w = w_even;
    end

    h_even    = {frame_height_i[SIZE_W-1:1], 1'b0};
    if (h_even < SIZE_W'(2)) begin
      used_h = SIZE_W'(2);
    end else if (h_even > SIZE_W'(MAX_HEIGHT)) begin
      used_h = SIZE_W'(MAX_HEIGHT);
    end else begin
      used_h = h_even;
    end

    col_inc   = WW'(col_q) + WW'(1);
    row_inc   = SIZE_W'(row_q) + SIZE_W'(1);
    row_end   = (col_inc >= used_w);
    frame_end = row_end && (row_inc >= used_h);

    odd_row   = row_q[0];
    odd_col   = col_q[0];
    chroma    = odd_row && odd_col;

    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
      if (odd_row && !odd_col) begin
        held_d = px;
      end
    end
  end

  // line store split into even and odd column banks, so both pixels above
  // a pair come out in the same cycle
  always_comb begin
    pair_addr = AW'(col_q >> 1);
    we_even   = accept && !odd_row && !odd_col;
    we_odd    = accept && !odd_row && odd_col;
    rd_pair   = accept && chroma;
  end

  b2y_ram #(
    .WIDTH (24),
    .DEPTH (PAIRS)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (pair_addr),
    .wdata_i (px),
    .re_i    (rd_pair),
    .raddr_i (pair_addr),
    .rdata_o (rd_even)
  );

  b2y_ram #(
    .WIDTH (24),
    .DEPTH (PAIRS)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (pair_addr),
    .wdata_i (px),
    .re_i    (rd_pair),
    .raddr_i (pair_addr),
    .rdata_o (rd_odd)
  );

  // counters and held pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      held_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      held_q     <= held_d;
      s1_valid_q <= accept;
    end
  end

  // stage that waits for the line store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q     <= px;
      s1_held_q   <= held_q;
      s1_chroma_q <= chroma;
      s1_last_q   <= frame_end;
    end
  end

  always_comb begin
    push_o.valid         = s1_valid_q;
    push_o.entry.px      = s1_px_q;
    push_o.entry.held    = s1_held_q;
    push_o.entry.above_l = rd_even;
    push_o.entry.above_r = rd_odd;
    push_o.entry.chroma  = s1_chroma_q;
    push_o.entry.last    = s1_last_q;
  end

endmodule

### rtl/core/b2y_back.sv
`timescale 1ns / 1ps

module b2y_back
  import b2y_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  b2y_entry_t  head_i,
  input  b2y_qstat_t  qstat_i,
  output logic        pop_o,
  b2y_result_if.source res
);

  // weights, 15 fractional bits
  localparam logic [14:0] K_Y_R   = 15'd9798;
  localparam logic [14:0] K_Y_G   = 15'd19235;
  localparam logic [14:0] K_Y_B   = 15'd3736;
  localparam logic [14:0] K_CB_R  = 15'd5538;
  localparam logic [14:0] K_CB_G  = 15'd10846;
  localparam logic [14:0] K_CB_B  = 15'd16351;
  localparam logic [14:0] K_CR_R  = 15'd16351;
  localparam logic [14:0] K_CR_G  = 15'd13697;
  localparam logic [14:0] K_CR_B  = 15'd2664;
  // chroma offset of 128 moved ahead of the shift
  localparam logic signed [24:0] C_BIAS = 25'sd4194304;

  function automatic logic [PIX_W-1:0] sat_u8(input logic signed [24:0] t);
    logic [PIX_W-1:0] r;
    if (t < 0) begin
      r = '0;
    end else if (t[23:15] > 9'd255) begin
      r = 8'd255;
    end else begin
      r = t[22:15];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
    logic [PIX_W+1:0] s;
    s = (PIX_W+2)'(a) + (PIX_W+2)'(b) + (PIX_W+2)'(c) + (PIX_W+2)'(d) + (PIX_W+2)'(2);
    return s[PIX_W+1:2];
  endfunction

  logic             en;
  logic             b1_valid_q, b2_valid_q, out_valid_q;
  logic [22:0]      b1_py_r_q, b1_py_g_q, b1_py_b_q;
  b2y_pix_t         b1_avg_q;
  logic             b1_chroma_q, b1_last_q;
  logic [PIX_W-1:0] b2_luma_q;
  logic [22:0]      b2_cb_r_q, b2_cb_g_q, b2_cb_b_q;
  logic [22:0]      b2_cr_r_q, b2_cr_g_q, b2_cr_b_q;
  logic             b2_chroma_q, b2_last_q;
  logic [PIX_W-1:0] out_luma_q, out_cb_q, out_cr_q;
  logic             out_chroma_q, out_last_q;

  b2y_pix_t           avg;
  logic [23:0]        y_sum;
  logic signed [24:0] t_cb, t_cr;

  // the whole pipe moves unless a result waits at the output
  assign en    = !out_valid_q || res.ready;
  assign pop_o = en && !qstat_i.empty;

  always_comb begin
    avg.red   = avg4(head_i.px.red, head_i.held.red, head_i.above_l.red, head_i.above_r.red);
    avg.green = avg4(head_i.px.green, head_i.held.green, head_i.above_l.green,
                     head_i.above_r.green);
    avg.blue  = avg4(head_i.px.blue, head_i.held.blue, head_i.above_l.blue, head_i.above_r.blue);
    y_sum     = 24'(b1_py_r_q) + 24'(b1_py_g_q) + 24'(b1_py_b_q);
    t_cb      = C_BIAS + $signed({2'b00, b2_cb_b_q}) - $signed({2'b00, b2_cb_r_q})
                - $signed({2'b00, b2_cb_g_q});
    t_cr      = C_BIAS + $signed({2'b00, b2_cr_r_q}) - $signed({2'b00, b2_cr_g_q})
                - $signed({2'b00, b2_cr_b_q});
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q  <= pop_o;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  // luma products and block average, then chroma products and luma,
  // then chroma sums into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_py_r_q   <= K_Y_R * 23'(head_i.px.red);
      b1_py_g_q   <= K_Y_G * 23'(head_i.px.green);
      b1_py_b_q   <= K_Y_B * 23'(head_i.px.blue);
      b1_avg_q    <= avg;
      b1_chroma_q <= head_i.chroma;
      b1_last_q   <= head_i.last;

      b2_luma_q   <= sat_u8($signed({1'b0, y_sum}));
      b2_cb_r_q   <= K_CB_R * 23'(b1_avg_q.red);
      b2_cb_g_q   <= K_CB_G * 23'(b1_avg_q.green);
      b2_cb_b_q   <= K_CB_B * 23'(b1_avg_q.blue);
      b2_cr_r_q   <= K_CR_R * 23'(b1_avg_q.red);
      b2_cr_g_q   <= K_CR_G * 23'(b1_avg_q.green);
      b2_cr_b_q   <= K_CR_B * 23'(b1_avg_q.blue);
      b2_chroma_q <= b1_chroma_q;
      b2_last_q   <= b1_last_q;

      out_luma_q   <= b2_luma_q;
      out_cb_q     <= b2_chroma_q ? sat_u8(t_cb) : '0;
      out_cr_q     <= b2_chroma_q ? sat_u8(t_cr) : '0;
      out_chroma_q <= b2_chroma_q;
      out_last_q   <= b2_last_q;
    end
  end

  assign res.valid            = out_valid_q;
  assign res.luma             = out_luma_q;
  assign res.chroma_valid     = out_chroma_q;
  assign res.chroma_blue_diff = out_cb_q;
  assign res.chroma_red_diff  = out_cr_q;
  assign res.frame_last       = out_last_q;

endmodule

### rtl/core/bgr_to_yuv420_converter_unit.sv
// path: an accepted pixel beat passes the front read stage, the queue and the back pipe
// throughput: one pixel per cycle unless the queue is full; the even and
//   odd column line store banks give both pixels above a pair in one read,
//   and the three-stage arithmetic pipe sits behind a four-entry queue
// reset: counters, held pixel and all valids clear; size registers return
//   to 640 x 480; the line store is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module bgr_to_yuv420_converter_unit
  import b2y_pkg::*;
#(
  parameter int MAX_WIDTH = B2Y_MAX_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  b2y_pixel_if.sink   pixel_i,
  b2y_result_if.source result_o
);

  logic [SIZE_W-1:0] frame_width_q, frame_width_d;
  logic [SIZE_W-1:0] frame_height_q, frame_height_d;
  logic              cfg_wr;
  b2y_push_t         push;
  b2y_entry_t        head;
  b2y_qstat_t        qstat;
  logic              pop;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH: begin
          frame_width_d = pwdata[SIZE_W-1:0];
        end
        REG_FRAME_HEIGHT: begin
          frame_height_d = pwdata[SIZE_W-1:0];
        end
        default: begin
          frame_width_d = frame_width_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH: begin
        prdata = 32'(frame_width_q);
      end
      REG_FRAME_HEIGHT: begin
        prdata = 32'(frame_height_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  b2y_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .pix            (pixel_i),
    .qstat_i        (qstat),
    .push_o         (push)
  );

  b2y_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  b2y_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .res     (result_o)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import b2y_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 300;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_TAIL   = 16;
  localparam int CYCLE_LIMIT  = 400000;

  // one output beat as the checker sees it
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             frame_last;
  } yuv_beat_t;

  // colour conversion predictor and queue of expected output beats
  class yuv_scoreboard;
    b2y_pix_t          line_px [B2Y_MAX_WIDTH];
    int unsigned       col;
    int unsigned       row;
    b2y_pix_t          held;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    yuv_beat_t         expected_q [$];
    int unsigned       errors;

    function new();
      foreach (line_px[i]) line_px[i] = '0;
      col        = 0;
      row        = 0;
      held       = '0;
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      errors     = 0;
    endfunction

    function void write_size(logic idx, logic [SIZE_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function int unsigned pending_count();
      return expected_q.size();
    endfunction

    // sizes rounded down to even and held within 2..max
    function int unsigned eff_width();
      int unsigned w;
      w = int'(width_reg) & ~1;
      if (w < 2) w = 2;
      if (w > (B2Y_MAX_WIDTH & ~1)) w = B2Y_MAX_WIDTH & ~1;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = int'(height_reg) & ~1;
      if (h < 2) h = 2;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    static function logic [PIX_W-1:0] clamp_byte(int v);
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[PIX_W-1:0];
    endfunction

    function void note_pixel(b2y_pix_t p);
      int unsigned w;
      int unsigned h;
      int          avg_b;
      int          avg_g;
      int          avg_r;
      b2y_pix_t    up_l;
      b2y_pix_t    up_r;
      yuv_beat_t   e;
      w = eff_width();
      h = eff_height();
      e = '0;
      e.luma = clamp_byte((9798 * int'(p.red) + 19235 * int'(p.green)
                           + 3736 * int'(p.blue)) >>> 15);
      if (row[0] == 1'b0) begin
        line_px[col] = p;
      end else if (col[0] == 1'b0) begin
        held = p;
      end else begin
        // rounded mean of the 2x2 block
        up_l  = line_px[col - 1];
        up_r  = line_px[col];
        avg_b = (int'(p.blue) + int'(held.blue) + int'(up_l.blue) + int'(up_r.blue) + 2) / 4;
        avg_g = (int'(p.green) + int'(held.green) + int'(up_l.green)
                 + int'(up_r.green) + 2) / 4;
        avg_r = (int'(p.red) + int'(held.red) + int'(up_l.red) + int'(up_r.red) + 2) / 4;
        e.cb  = clamp_byte(((-5538 * avg_r - 10846 * avg_g + 16351 * avg_b) >>> 15) + 128);
        e.cr  = clamp_byte(((16351 * avg_r - 13697 * avg_g - 2664 * avg_b) >>> 15) + 128);
        e.chroma_valid = 1'b1;
      end
      // row and frame position
      if (col + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) begin
          row = 0;
          e.frame_last = 1'b1;
        end else begin
          row = row + 1;
        end
      end else begin
        col = col + 1;
      end
      expected_q.push_back(e);
    endfunction

    function void report(string field, int exp_v, int act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(yuv_beat_t got);
      yuv_beat_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: output beat with nothing expected, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.luma !== e.luma) report("luma", e.luma, got.luma);
      if (got.chroma_valid !== e.chroma_valid)
        report("chroma_valid", e.chroma_valid, got.chroma_valid);
      if (got.frame_last !== e.frame_last) report("frame_last", e.frame_last, got.frame_last);
      // chroma is zero on beats that close no block
      if (got.cb !== e.cb) report("chroma_blue_diff", e.cb, got.cb);
      if (got.cr !== e.cr) report("chroma_red_diff", e.cr, got.cr);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  b2y_pixel_if  pix_if ();
  b2y_result_if res_if ();

  yuv_scoreboard sb;
  int unsigned   cycle_count;
  bit            no_idle;
  bit            long_hold_req;
  b2y_pix_t      directed_px [24];

  bgr_to_yuv420_converter_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pixel_i  (pix_if),
    .result_o (res_if)
  );

  // clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run time guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result({res_if.luma, res_if.chroma_valid, res_if.chroma_blue_diff,
                       res_if.chroma_red_diff, res_if.frame_last});
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (stall != 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic send_pixel(input b2y_pix_t p);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap != 0) begin
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.blue  = p.blue;
    pix_if.green = p.green;
    pix_if.red   = p.red;
    do @(posedge clk_i); while (!pix_if.ready);
    sb.note_pixel(p);
  endtask

  // drop valid after the last beat of a burst
  task automatic end_burst();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  function automatic b2y_pix_t random_pixel();
    b2y_pix_t p;
    if ($urandom_range(0, 3) == 0) begin
      p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end else begin
      p.blue  = PIX_W'($urandom_range(0, 255));
      p.green = PIX_W'($urandom_range(0, 255));
      p.red   = PIX_W'($urandom_range(0, 255));
    end
    return p;
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // size write on an idle block, setup then access beat
  task automatic set_size(input logic idx, input logic [SIZE_W-1:0] value);
    end_burst();
    wait_drained();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {20'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_size(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // width only changes on an even row, so an odd row never reads a line
  // entry that the row above left unwritten
  task automatic set_width(input logic [SIZE_W-1:0] value);
    if (sb.row[0] == 1'b0) set_size(REG_FRAME_WIDTH, value);
  endtask

  function automatic logic [SIZE_W-1:0] pick_width();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0:       return 12'd0;
        1:       return 12'd1;
        2:       return 12'd3;
        3:       return 12'd2049;
        default: return 12'hFFF;
      endcase
    end
    if (sel < 3) return SIZE_W'($urandom_range(2, 40));
    return SIZE_W'($urandom_range(2, 12));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_height();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 12'd0;
        1:       return 12'd1;
        2:       return 12'd3;
        default: return 12'hFFF;
      endcase
    end
    return SIZE_W'($urandom_range(2, 8));
  endfunction

  initial begin : stimulus
    int unsigned random_items;
    int unsigned phase;
    int unsigned n;
    sb            = new();
    cycle_count   = 0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pix_if.valid  = 1'b0;
    pix_if.blue   = '0;
    pix_if.green  = '0;
    pix_if.red    = '0;

    // three 4x2 frames: white and black, pure blue and red, green, yellow
    // and a block whose rounding drops the fraction
    directed_px = '{
      24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
      24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
      24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000,
      24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000,
      24'h00FF00, 24'h00FF00, 24'hFFFF00, 24'hFFFF00,
      24'h00FF00, 24'h00FF00, 24'h010203, 24'h000102
    };

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames
    set_size(REG_FRAME_WIDTH, 12'd4);
    set_size(REG_FRAME_HEIGHT, 12'd2);
    foreach (directed_px[i]) send_pixel(directed_px[i]);

    // oversized frame clamps to the widest row, then a narrow width in
    // mid row, then a height below the current row
    set_size(REG_FRAME_WIDTH, 12'hFFF);
    set_size(REG_FRAME_HEIGHT, 12'hFFF);
    no_idle = 1'b1;
    send_random(40);
    no_idle = 1'b0;
    set_width(12'd6);
    send_random(40);
    set_size(REG_FRAME_HEIGHT, 12'd3);
    send_random(14);

    // random phases with size changes in between
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        set_width(12'd0);
        set_size(REG_FRAME_HEIGHT, 12'd1);
      end else if (phase == 1) begin
        set_width(12'd3);
        set_size(REG_FRAME_HEIGHT, 12'd3);
      end else begin
        if ($urandom_range(0, 3) != 0) set_width(pick_width());
        if ($urandom_range(0, 1) != 0) set_size(REG_FRAME_HEIGHT, pick_height());
      end
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // output held off while pixels keep coming
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
        n             = 30;
      end else begin
        n = $urandom_range(5, 35);
      end
      send_random(n);
      random_items += n;
      if (phase == 3) begin
        end_burst();
        wait_drained();
      end
      phase++;
    end

    // drain and finish
    end_burst();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
